[design/assert_macros.svh]
// Assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[design/cdr_pkg.sv]
// Types and constants of the cable direction and rate block.
`timescale 1ns / 1ps
`default_nettype none
package cdr_pkg;

  // Field and datapath widths.
  localparam int COORD_W  = 32;
  localparam int DIFF_W   = 33;
  localparam int SQ_W     = 66;
  localparam int LEN_W    = 33;
  localparam int DIR_QW   = 31;
  localparam int DIR_FRAC = 30;
  localparam int RATE_QW  = 32;
  localparam int PROD_W   = 65;
  localparam int MAG_W    = 64;
  localparam int NQ_W     = 51;
  localparam int MINLEN_W = 17;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // Register map.
  localparam logic REG_MIN_LENGTH = 1'b0;
  localparam logic [MINLEN_W-1:0] MINLEN_RESET = 17'd1;

  // Output limits.
  localparam logic [COORD_W-1:0] RATE_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] RATE_NEG_MAX = 32'h8000_0000;
  localparam logic signed [COORD_W-1:0] DIR_ONE = 32'sh4000_0000;

  typedef struct packed {
    logic signed [COORD_W-1:0] vehicle_pos_x;
    logic signed [COORD_W-1:0] vehicle_pos_y;
    logic signed [COORD_W-1:0] vehicle_pos_z;
    logic signed [COORD_W-1:0] load_pos_x;
    logic signed [COORD_W-1:0] load_pos_y;
    logic signed [COORD_W-1:0] load_pos_z;
    logic signed [COORD_W-1:0] vehicle_vel_x;
    logic signed [COORD_W-1:0] vehicle_vel_y;
    logic signed [COORD_W-1:0] vehicle_vel_z;
    logic signed [COORD_W-1:0] load_vel_x;
    logic signed [COORD_W-1:0] load_vel_y;
    logic signed [COORD_W-1:0] load_vel_z;
  } in_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;
    logic signed [COORD_W-1:0] rate_x;
    logic signed [COORD_W-1:0] rate_y;
    logic signed [COORD_W-1:0] rate_z;
  } out_word_t;

  // Carried alongside the square root: offset magnitudes, signs, velocity difference.
  typedef struct packed {
    logic [2:0][DIFF_W-1:0] mag;
    logic [2:0]             neg;
    logic [2:0][DIFF_W-1:0] vel;
  } gside_t;

  // Carried alongside the direction divider.
  typedef struct packed {
    logic [2:0]             neg;
    logic [2:0][DIFF_W-1:0] vel;
  } dside_t;

  // Carried alongside the rate divider.
  typedef struct packed {
    logic [2:0]              neg;
    logic [2:0]              ovf;
    logic [2:0][COORD_W-1:0] dir;
  } rside_t;

endpackage
`default_nettype wire

[design/cdr_sqrt_pipe.sv]
// Pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module cdr_sqrt_pipe #(
  parameter int SideW = 8
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        en,
  input  wire                        in_valid,
  input  wire [cdr_pkg::SQ_W-1:0]    in_rad,
  input  wire [SideW-1:0]            in_side,
  output logic                       out_valid,
  output logic [cdr_pkg::LEN_W-1:0]  out_root,
  output logic [SideW-1:0]           out_side
);
  import cdr_pkg::*;

  localparam int Steps = LEN_W;
  localparam int RemW  = LEN_W + 2;

  logic             v_r      [Steps];
  logic [RemW-1:0]  rem_r    [Steps];
  logic [LEN_W-1:0] root_r   [Steps];
  logic [SQ_W-1:0]  rad_r    [Steps];
  logic [SideW-1:0] side_r   [Steps];

  logic             v_in     [Steps];
  logic [RemW-1:0]  rem_in   [Steps];
  logic [LEN_W-1:0] root_in  [Steps];
  logic [SQ_W-1:0]  rad_in   [Steps];
  logic [SideW-1:0] side_in  [Steps];

  logic [RemW-1:0]  rem_nxt  [Steps];
  logic [LEN_W-1:0] root_nxt [Steps];
  logic [SQ_W-1:0]  rad_nxt  [Steps];

  // Each stage reads the stage before it; the first reads the ports.
  always_comb begin
    v_in[0]    = in_valid;
    rem_in[0]  = '0;
    root_in[0] = '0;
    rad_in[0]  = in_rad;
    side_in[0] = in_side;
    for (int k = 1; k < Steps; k++) begin
      v_in[k]    = v_r[k-1];
      rem_in[k]  = rem_r[k-1];
      root_in[k] = root_r[k-1];
      rad_in[k]  = rad_r[k-1];
      side_in[k] = side_r[k-1];
    end
  end

  // One trial subtraction per stage: bring down two radicand bits, try 4*root+1.
  always_comb begin
    logic [RemW+1:0] tst;
    logic [RemW+1:0] trial;
    logic            fits;
    for (int k = 0; k < Steps; k++) begin
      tst         = {rem_in[k], rad_in[k][SQ_W-1 -: 2]};
      trial       = {2'b00, root_in[k], 2'b01};
      fits        = (tst >= trial);
      rem_nxt[k]  = fits ? RemW'(tst - trial) : RemW'(tst);
      root_nxt[k] = {root_in[k][LEN_W-2:0], fits};
      rad_nxt[k]  = {rad_in[k][SQ_W-3:0], 2'b00};
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < Steps; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < Steps; k++) v_r[k] <= v_in[k];
    end
  end

  // Stage data.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < Steps; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
        side_r[k] <= side_in[k];
      end
    end
  end

  assign out_valid = v_r[Steps-1];
  assign out_root  = root_r[Steps-1];
  assign out_side  = side_r[Steps-1];

endmodule
`default_nettype wire

[design/cdr_div_pipe.sv]
// Pipelined restoring divider, several lanes over one divisor, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module cdr_div_pipe #(
  parameter int QuoW  = 31,
  parameter int DenW  = 33,
  parameter int Lanes = 3,
  parameter int SideW = 8
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               en,
  input  wire                               in_valid,
  input  wire [DenW-1:0]                    in_den,
  input  wire [Lanes-1:0][DenW-1:0]         in_rem,
  input  wire [Lanes-1:0][QuoW-1:0]         in_low,
  input  wire [SideW-1:0]                   in_side,
  output logic                              out_valid,
  output logic [DenW-1:0]                   out_den,
  output logic [Lanes-1:0][QuoW-1:0]        out_quo,
  output logic [SideW-1:0]                  out_side
);

  logic                       v_r     [QuoW];
  logic [DenW-1:0]            den_r   [QuoW];
  logic [Lanes-1:0][DenW-1:0] rem_r   [QuoW];
  logic [Lanes-1:0][QuoW-1:0] low_r   [QuoW];
  logic [SideW-1:0]           side_r  [QuoW];

  logic                       v_in    [QuoW];
  logic [DenW-1:0]            den_in  [QuoW];
  logic [Lanes-1:0][DenW-1:0] rem_in  [QuoW];
  logic [Lanes-1:0][QuoW-1:0] low_in  [QuoW];
  logic [SideW-1:0]           side_in [QuoW];

  logic [Lanes-1:0][DenW-1:0] rem_nxt [QuoW];
  logic [Lanes-1:0][QuoW-1:0] low_nxt [QuoW];

  // Each stage reads the stage before it; the first reads the ports.
  always_comb begin
    v_in[0]    = in_valid;
    den_in[0]  = in_den;
    rem_in[0]  = in_rem;
    low_in[0]  = in_low;
    side_in[0] = in_side;
    for (int k = 1; k < QuoW; k++) begin
      v_in[k]    = v_r[k-1];
      den_in[k]  = den_r[k-1];
      rem_in[k]  = rem_r[k-1];
      low_in[k]  = low_r[k-1];
      side_in[k] = side_r[k-1];
    end
  end

  // Shift in the next dividend bit, subtract the divisor when it fits.
  // The low word drains dividend bits out the top and takes quotient bits in at the bottom.
  always_comb begin
    logic [DenW:0] tst;
    logic          fits;
    for (int k = 0; k < QuoW; k++) begin
      for (int l = 0; l < Lanes; l++) begin
        tst              = {rem_in[k][l], low_in[k][l][QuoW-1]};
        fits             = (tst >= {1'b0, den_in[k]});
        rem_nxt[k][l]    = fits ? DenW'(tst - {1'b0, den_in[k]}) : DenW'(tst);
        low_nxt[k][l]    = {low_in[k][l][QuoW-2:0], fits};
      end
    end
  end

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QuoW; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < QuoW; k++) v_r[k] <= v_in[k];
    end
  end

  // Stage data.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QuoW; k++) begin
        den_r[k]  <= den_in[k];
        rem_r[k]  <= rem_nxt[k];
        low_r[k]  <= low_nxt[k];
        side_r[k] <= side_in[k];
      end
    end
  end

  assign out_valid = v_r[QuoW-1];
  assign out_den   = den_r[QuoW-1];
  assign out_quo   = low_r[QuoW-1];
  assign out_side  = side_r[QuoW-1];

endmodule
`default_nettype wire

[design/cable_direction_and_rate.sv]
// Top level: cable direction and angular rate of a slung load, fully pipelined.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
//
// Channel   Handshake              Word
// in_       in_valid / in_stall    in_word  (vehicle and load position, velocity)
// out_      out_valid / out_stall  out_word (unit direction, angular rate)
// config    psel/penable/pwrite    min_length at byte address 0, pready always high
//
// One sample set enters per cycle while in_stall is low.
// The depth is set by the 33-stage square root and the 31- and 32-stage dividers.
// Sets whose length is zero or below min_length are dropped after the square root.
// The whole pipeline holds only while its last stage is full and the output word is stalled.
// Reset clears all valid bits and sets min_length to 1.
//
module cable_direction_and_rate (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire cdr_pkg::in_word_t       in_word,
  output logic                         out_valid,
  input  wire                          out_stall,
  output cdr_pkg::out_word_t           out_word,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [cdr_pkg::ADDR_W-1:0]    paddr,
  input  wire [cdr_pkg::DATA_W-1:0]    pwdata,
  output logic [cdr_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import cdr_pkg::*;

  logic                    pipe_en;
  logic                    load_out;
  logic [MINLEN_W-1:0]     min_length_r;

  logic signed [COORD_W-1:0] veh_pos [3];
  logic signed [COORD_W-1:0] ld_pos  [3];
  logic signed [COORD_W-1:0] veh_vel [3];
  logic signed [COORD_W-1:0] ld_vel  [3];

  // Stage A: offsets and velocity difference.
  logic        a_v_r;
  gside_t      a_side_r, a_side_nxt;
  // Stage B: squares.
  logic        b_v_r;
  gside_t      b_side_r;
  logic [SQ_W-1:0] b_sq_r [3];
  logic [SQ_W-1:0] b_sq_nxt [3];
  // Stage C: sum of squares.
  logic        c_v_r;
  gside_t      c_side_r;
  logic [SQ_W-1:0] c_sum_r;
  // Square root output.
  logic                     sq_v;
  logic [LEN_W-1:0]         sq_root;
  logic [$bits(gside_t)-1:0] sq_side_vec;
  gside_t                   sq_side;
  // Stage D: length check and divider set-up.
  logic                     keep;
  logic                     d_v_r;
  logic [LEN_W-1:0]         d_len_r;
  logic [2:0][LEN_W-1:0]    d_rem_r, d_rem_nxt;
  logic [2:0][DIR_QW-1:0]   d_low_r, d_low_nxt;
  dside_t                   d_side_r, d_side_nxt;
  // Direction divider output.
  logic                      dv_v;
  logic [LEN_W-1:0]          dv_len;
  logic [2:0][DIR_QW-1:0]    dv_quo;
  logic [$bits(dside_t)-1:0] dv_side_vec;
  dside_t                    dv_side;
  // Stage E: signed direction.
  logic                     e_v_r;
  logic [LEN_W-1:0]         e_len_r;
  logic [2:0][COORD_W-1:0]  e_u_r, e_u_nxt;
  logic [2:0][DIFF_W-1:0]   e_vel_r;
  // Stage F: cross product terms.
  logic                     f_v_r;
  logic [LEN_W-1:0]         f_len_r;
  logic [2:0][COORD_W-1:0]  f_u_r;
  logic signed [PROD_W-1:0] f_pp_r [3];
  logic signed [PROD_W-1:0] f_pn_r [3];
  logic signed [PROD_W-1:0] f_pp_nxt [3];
  logic signed [PROD_W-1:0] f_pn_nxt [3];
  // Stage G: cross product magnitude and sign.
  logic                     g_v_r;
  logic [LEN_W-1:0]         g_len_r;
  logic [2:0][COORD_W-1:0]  g_u_r;
  logic [2:0]               g_neg_r, g_neg_nxt;
  logic [MAG_W-1:0]         g_mag_r [3];
  logic [MAG_W-1:0]         g_mag_nxt [3];
  // Stage H: rounded and scaled rate dividend.
  logic                     h_v_r;
  logic [LEN_W-1:0]         h_len_r;
  logic [2:0][COORD_W-1:0]  h_u_r;
  logic [2:0]               h_neg_r;
  logic [NQ_W-1:0]          h_nq_r [3];
  logic [NQ_W-1:0]          h_nq_nxt [3];
  // Rate divider set-up and output.
  logic [2:0][LEN_W-1:0]     rd_rem;
  logic [2:0][RATE_QW-1:0]   rd_low;
  rside_t                    rd_side;
  logic                      rv_v;
  logic [2:0][RATE_QW-1:0]   rv_quo;
  logic [$bits(rside_t)-1:0] rv_side_vec;
  rside_t                    rv_side;
  // Final stage and output word.
  logic                     fin_v_r;
  out_word_t                fin_word_r, fin_word_nxt;
  logic                     out_valid_r;
  out_word_t                out_word_r;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MIN_LENGTH) ? DATA_W'(min_length_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_length_r <= MINLEN_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MIN_LENGTH)) begin
      min_length_r <= pwdata[MINLEN_W-1:0];
    end
  end

  // Flow control: hold the pipe only when the final word cannot move on.
  assign load_out = !out_valid_r || !out_stall;
  assign pipe_en  = !(fin_v_r && !load_out);
  assign in_stall = !pipe_en;

  // Component views of the input word.
  assign veh_pos[0] = in_word.vehicle_pos_x;
  assign veh_pos[1] = in_word.vehicle_pos_y;
  assign veh_pos[2] = in_word.vehicle_pos_z;
  assign ld_pos[0]  = in_word.load_pos_x;
  assign ld_pos[1]  = in_word.load_pos_y;
  assign ld_pos[2]  = in_word.load_pos_z;
  assign veh_vel[0] = in_word.vehicle_vel_x;
  assign veh_vel[1] = in_word.vehicle_vel_y;
  assign veh_vel[2] = in_word.vehicle_vel_z;
  assign ld_vel[0]  = in_word.load_vel_x;
  assign ld_vel[1]  = in_word.load_vel_y;
  assign ld_vel[2]  = in_word.load_vel_z;

  // Stage A: exact 33-bit offsets, their magnitudes and the velocity difference.
  always_comb begin
    logic [DIFF_W-1:0] dpos;
    for (int i = 0; i < 3; i++) begin
      dpos = {ld_pos[i][COORD_W-1], ld_pos[i]} - {veh_pos[i][COORD_W-1], veh_pos[i]};
      a_side_nxt.neg[i] = dpos[DIFF_W-1];
      a_side_nxt.mag[i] = dpos[DIFF_W-1] ? (~dpos + DIFF_W'(1)) : dpos;
      a_side_nxt.vel[i] = {ld_vel[i][COORD_W-1], ld_vel[i]}
                        - {veh_vel[i][COORD_W-1], veh_vel[i]};
    end
  end

  // Stage B: squares of the magnitudes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_sq_nxt[i] = SQ_W'(a_side_r.mag[i]) * SQ_W'(a_side_r.mag[i]);
    end
  end

  cdr_sqrt_pipe #(
    .SideW ($bits(gside_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (c_v_r),
    .in_rad    (c_sum_r),
    .in_side   (c_side_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_side  (sq_side_vec)
  );
  assign sq_side = sq_side_vec;

  // Stage D: drop short cables, form |d| * 2^30 + len/2 and split it for the divider.
  assign keep = (sq_root != '0) && (sq_root >= LEN_W'(min_length_r));

  always_comb begin
    logic [MAG_W-1:0] num;
    for (int i = 0; i < 3; i++) begin
      num = {1'b0, sq_side.mag[i], {DIR_FRAC{1'b0}}}
          + {{(MAG_W-LEN_W+1){1'b0}}, sq_root[LEN_W-1:1]};
      d_rem_nxt[i] = num[MAG_W-1 -: LEN_W];
      d_low_nxt[i] = num[DIR_QW-1:0];
    end
    d_side_nxt.neg = sq_side.neg;
    d_side_nxt.vel = sq_side.vel;
  end

  cdr_div_pipe #(
    .QuoW  (DIR_QW),
    .DenW  (LEN_W),
    .Lanes (3),
    .SideW ($bits(dside_t))
  ) u_dir_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (d_v_r),
    .in_den    (d_len_r),
    .in_rem    (d_rem_r),
    .in_low    (d_low_r),
    .in_side   (d_side_r),
    .out_valid (dv_v),
    .out_den   (dv_len),
    .out_quo   (dv_quo),
    .out_side  (dv_side_vec)
  );
  assign dv_side = dv_side_vec;

  // Stage E: give the rounded direction the sign of the offset.
  always_comb begin
    logic [COORD_W-1:0] uq;
    for (int i = 0; i < 3; i++) begin
      uq         = {1'b0, dv_quo[i]};
      e_u_nxt[i] = dv_side.neg[i] ? (~uq + COORD_W'(1)) : uq;
    end
  end

  // Stage F: the six products of the cross product direction x velocity.
  always_comb begin
    f_pp_nxt[0] = $signed(e_u_r[1]) * $signed(e_vel_r[2]);
    f_pn_nxt[0] = $signed(e_u_r[2]) * $signed(e_vel_r[1]);
    f_pp_nxt[1] = $signed(e_u_r[2]) * $signed(e_vel_r[0]);
    f_pn_nxt[1] = $signed(e_u_r[0]) * $signed(e_vel_r[2]);
    f_pp_nxt[2] = $signed(e_u_r[0]) * $signed(e_vel_r[1]);
    f_pn_nxt[2] = $signed(e_u_r[1]) * $signed(e_vel_r[0]);
  end

  // Stage G: magnitude and sign of each cross product component.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_neg_nxt[i] = (f_pp_r[i] < f_pn_r[i]);
      g_mag_nxt[i] = g_neg_nxt[i] ? MAG_W'(f_pn_r[i] - f_pp_r[i])
                                  : MAG_W'(f_pp_r[i] - f_pn_r[i]);
    end
  end

  // Stage H: add half the divisor (len * 2^13) and drop the 2^14 scale.
  always_comb begin
    logic [MAG_W:0] sum;
    for (int i = 0; i < 3; i++) begin
      sum = {1'b0, g_mag_r[i]} + {{(MAG_W-LEN_W-12){1'b0}}, g_len_r, 13'b0};
      h_nq_nxt[i] = sum[MAG_W -: NQ_W];
    end
  end

  // Rate divider set-up; a high part at or above len means the quotient needs saturation.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rd_rem[i]      = {{(LEN_W-(NQ_W-RATE_QW)){1'b0}}, h_nq_r[i][NQ_W-1:RATE_QW]};
      rd_low[i]      = h_nq_r[i][RATE_QW-1:0];
      rd_side.ovf[i] = (rd_rem[i] >= h_len_r);
    end
    rd_side.neg = h_neg_r;
    rd_side.dir = h_u_r;
  end

  cdr_div_pipe #(
    .QuoW  (RATE_QW),
    .DenW  (LEN_W),
    .Lanes (3),
    .SideW ($bits(rside_t))
  ) u_rate_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (h_v_r),
    .in_den    (h_len_r),
    .in_rem    (rd_rem),
    .in_low    (rd_low),
    .in_side   (rd_side),
    .out_valid (rv_v),
    .out_den   (),
    .out_quo   (rv_quo),
    .out_side  (rv_side_vec)
  );
  assign rv_side = rv_side_vec;

  // Final stage: sign and saturate the rate, assemble the result word.
  always_comb begin
    logic [COORD_W-1:0] rate [3];
    logic [COORD_W-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = rv_quo[i];
      if (rv_side.neg[i]) begin
        if (rv_side.ovf[i] || (q > RATE_NEG_MAX)) begin
          rate[i] = RATE_NEG_MAX;
        end else begin
          rate[i] = ~q + COORD_W'(1);
        end
      end else begin
        if (rv_side.ovf[i] || q[COORD_W-1]) begin
          rate[i] = RATE_POS_MAX;
        end else begin
          rate[i] = q;
        end
      end
    end
    fin_word_nxt.dir_x  = rv_side.dir[0];
    fin_word_nxt.dir_y  = rv_side.dir[1];
    fin_word_nxt.dir_z  = rv_side.dir[2];
    fin_word_nxt.rate_x = rate[0];
    fin_word_nxt.rate_y = rate[1];
    fin_word_nxt.rate_z = rate[2];
  end

  // Valid bits of the local stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      d_v_r   <= 1'b0;
      e_v_r   <= 1'b0;
      f_v_r   <= 1'b0;
      g_v_r   <= 1'b0;
      h_v_r   <= 1'b0;
      fin_v_r <= 1'b0;
    end else if (pipe_en) begin
      a_v_r   <= in_valid;
      b_v_r   <= a_v_r;
      c_v_r   <= b_v_r;
      d_v_r   <= sq_v && keep;
      e_v_r   <= dv_v;
      f_v_r   <= e_v_r;
      g_v_r   <= f_v_r;
      h_v_r   <= g_v_r;
      fin_v_r <= rv_v;
    end
  end

  // Data of the local stages.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      a_side_r   <= a_side_nxt;
      b_side_r   <= a_side_r;
      c_side_r   <= b_side_r;
      c_sum_r    <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
      d_len_r    <= sq_root;
      d_rem_r    <= d_rem_nxt;
      d_low_r    <= d_low_nxt;
      d_side_r   <= d_side_nxt;
      e_len_r    <= dv_len;
      e_u_r      <= e_u_nxt;
      e_vel_r    <= dv_side.vel;
      f_len_r    <= e_len_r;
      f_u_r      <= e_u_r;
      g_len_r    <= f_len_r;
      g_u_r      <= f_u_r;
      g_neg_r    <= g_neg_nxt;
      h_len_r    <= g_len_r;
      h_u_r      <= g_u_r;
      h_neg_r    <= g_neg_r;
      fin_word_r <= fin_word_nxt;
      for (int i = 0; i < 3; i++) begin
        b_sq_r[i] <= b_sq_nxt[i];
        f_pp_r[i] <= f_pp_nxt[i];
        f_pn_r[i] <= f_pn_nxt[i];
        g_mag_r[i] <= g_mag_nxt[i];
        h_nq_r[i] <= h_nq_nxt[i];
      end
    end
  end

  // Output register: parts the pipeline from the consumer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= fin_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && fin_v_r) begin
      out_word_r <= fin_word_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // A full last stage behind a stalled output word must hold the input side.
  `ASSERT_IMPLIES(a_hold_input, fin_v_r && out_valid_r && out_stall, in_stall, "input taken while the pipeline is blocked")
  // With the output register empty the pipeline always moves.
  `ASSERT_IMPLIES(a_free_input, !out_valid_r, !in_stall, "input stalled while the output register is empty")
  // The x component of the unit direction never exceeds one in magnitude.
  `ASSERT_ALWAYS(a_dir_range, !out_valid_r || (($signed(out_word_r.dir_x) <= DIR_ONE) && ($signed(out_word_r.dir_x) >= -DIR_ONE)), "direction component out of range")

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the cable direction and angular rate block.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
  import cdr_pkg::*;

  // Register byte addresses; the spare one lies past the register map.
  localparam logic [ADDR_W-1:0] ADDR_MIN_LENGTH = {REG_MIN_LENGTH, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SPARE      = 3'd4;
  localparam int DRAIN_CYCLES = 150;
  localparam int STALL_LIMIT  = 5000;
  localparam int PHASES       = 6;
  localparam int SETS_PER_PHASE = 170;

  typedef enum logic [1:0] {ROW_NO_RESULT, ROW_TYPED, ROW_PREDICTED} row_kind_t;
  typedef struct {
    row_kind_t kind;
    in_word_t  set_in;
    out_word_t typed_out;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  out_word_t pending_results[$];
  logic [MINLEN_W-1:0] min_len_shadow;
  int errors = 0;
  int results_seen = 0;
  int sets_sent = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;
  int stall_left = 0;

  cable_direction_and_rate DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One rate component: (p - n) / (len * 2^14), rounded half away, saturated.
  function automatic logic [31:0] rate_of(logic signed [31:0] ua, logic signed [32:0] vb,
                                          logic signed [31:0] uc, logic signed [32:0] vd,
                                          logic [33:0] len);
    logic signed [65:0] p, n, df;
    logic [65:0] mag, dv, q;
    p = 66'(ua) * 66'(vb);
    n = 66'(uc) * 66'(vd);
    df = p - n;
    mag = (df < 0) ? 66'(-df) : 66'(df);
    dv = 66'(len) << 14;
    q = (mag + (dv >> 1)) / dv;
    if (df < 0) begin
      if (q > 66'h8000_0000) q = 66'h8000_0000;
      return -q[31:0];
    end
    if (q > 66'h7FFF_FFFF) q = 66'h7FFF_FFFF;
    return q[31:0];
  endfunction

  // Cable direction and rate of one sample set; returns 0 when no result is due.
  function automatic bit cable_solution(in_word_t w, logic [MINLEN_W-1:0] mlen,
                                        output out_word_t r);
    logic signed [32:0] d[3], v[3];
    logic [32:0] m[3];
    logic [65:0] ssq;
    logic [33:0] len, c;
    logic [63:0] q;
    logic signed [31:0] u[3];
    r = '0;
    d[0] = 33'(w.load_pos_x) - 33'(w.vehicle_pos_x);
    d[1] = 33'(w.load_pos_y) - 33'(w.vehicle_pos_y);
    d[2] = 33'(w.load_pos_z) - 33'(w.vehicle_pos_z);
    v[0] = 33'(w.load_vel_x) - 33'(w.vehicle_vel_x);
    v[1] = 33'(w.load_vel_y) - 33'(w.vehicle_vel_y);
    v[2] = 33'(w.load_vel_z) - 33'(w.vehicle_vel_z);
    ssq = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (d[i] < 0) ? 33'(-d[i]) : 33'(d[i]);
      ssq += 66'(m[i]) * 66'(m[i]);
    end
    // Floor square root, one bit per step from the top.
    len = '0;
    for (int b = 33; b >= 0; b--) begin
      c = len | (34'd1 << b);
      if (68'(c) * 68'(c) <= 68'(ssq)) len = c;
    end
    if (len == 0 || len < 34'(mlen)) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      q = ((64'(m[i]) << 30) + (64'(len) >> 1)) / 64'(len);
      u[i] = (d[i] < 0) ? -q[31:0] : q[31:0];
    end
    r.dir_x = u[0];
    r.dir_y = u[1];
    r.dir_z = u[2];
    r.rate_x = rate_of(u[1], v[2], u[2], v[1], len);
    r.rate_y = rate_of(u[2], v[0], u[0], v[2], len);
    r.rate_z = rate_of(u[0], v[1], u[1], v[0], len);
    return 1'b1;
  endfunction

  // Random sample set; most keep the load near the vehicle so lengths straddle the minimum.
  function automatic in_word_t random_set();
    in_word_t w;
    int mode;
    w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      w.load_pos_x = w.vehicle_pos_x + 32'($urandom_range(0, 1 << 19) - (1 << 18));
      w.load_pos_y = w.vehicle_pos_y + 32'($urandom_range(0, 1 << 19) - (1 << 18));
      w.load_pos_z = w.vehicle_pos_z + 32'($urandom_range(0, 1 << 19) - (1 << 18));
    end else if (mode == 6) begin
      w.load_pos_x = w.vehicle_pos_x;
      w.load_pos_y = w.vehicle_pos_y;
      w.load_pos_z = w.vehicle_pos_z;
    end else if (mode == 7) begin
      // Tiny cable with full-range velocities drives the rates into saturation.
      w.load_pos_x = w.vehicle_pos_x + 32'($urandom_range(0, 8) - 4);
      w.load_pos_y = w.vehicle_pos_y + 32'($urandom_range(0, 8) - 4);
      w.load_pos_z = w.vehicle_pos_z + 32'($urandom_range(0, 8) - 4);
    end
    if (mode < 4) begin
      w.load_vel_x = w.vehicle_vel_x + 32'($urandom_range(0, 1 << 20) - (1 << 19));
      w.load_vel_y = w.vehicle_vel_y + 32'($urandom_range(0, 1 << 20) - (1 << 19));
      w.load_vel_z = w.vehicle_vel_z + 32'($urandom_range(0, 1 << 20) - (1 << 19));
    end
    return w;
  endfunction

  // Sends one word, with an occasional idle burst first, and books its result.
  task automatic send_set(row_kind_t kind, in_word_t w, out_word_t typed);
    int gap;
    out_word_t r;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      gap = $urandom_range(1, 17);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_word <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sets_sent++;
    if (kind == ROW_TYPED) begin
      pending_results.push_back(typed);
    end else if (kind == ROW_PREDICTED && cable_solution(w, min_len_shadow, r)) begin
      pending_results.push_back(r);
    end
  endtask

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_MIN_LENGTH) min_len_shadow = data[MINLEN_W-1:0];
  endtask

  // Holds the sender until every booked result is out, then lets the pipe settle.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver stall in random bursts; none at all in the quiet part.
  always @(negedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (rst_n && $urandom_range(0, 15) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(1, 17) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: %h", out_word);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_word.dir_x !== e.dir_x) begin
          $error("dir_x expected %h actual %h", e.dir_x, out_word.dir_x); errors++;
        end
        if (out_word.dir_y !== e.dir_y) begin
          $error("dir_y expected %h actual %h", e.dir_y, out_word.dir_y); errors++;
        end
        if (out_word.dir_z !== e.dir_z) begin
          $error("dir_z expected %h actual %h", e.dir_z, out_word.dir_z); errors++;
        end
        if (out_word.rate_x !== e.rate_x) begin
          $error("rate_x expected %h actual %h", e.rate_x, out_word.rate_x); errors++;
        end
        if (out_word.rate_y !== e.rate_y) begin
          $error("rate_y expected %h actual %h", e.rate_y, out_word.rate_y); errors++;
        end
        if (out_word.rate_z !== e.rate_z) begin
          $error("rate_z expected %h actual %h", e.rate_z, out_word.rate_z); errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake of any kind.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // Directed rows, then random phases under several minimum lengths.
  initial begin
    stim_row_t rows[$];
    stim_row_t row;
    logic [DATA_W-1:0] min_settings[PHASES];
    min_len_shadow = MINLEN_RESET;
    min_settings = '{32'd0, 32'h0000_FFFF, 32'h0001_0000, 32'd1, 32'd3, 32'd0};
    min_settings[4] = $urandom_range(0, 65536);

    // Zero length gives nothing.
    row.kind = ROW_NO_RESULT; row.set_in = '0; row.typed_out = '0;
    rows.push_back(row);
    // One metre along +x, at rest: unit x, no rate.
    row.kind = ROW_TYPED; row.set_in = '0; row.set_in.load_pos_x = 32'sh0001_0000;
    row.typed_out = '0; row.typed_out.dir_x = DIR_ONE;
    rows.push_back(row);
    // One metre along -y.
    row.set_in = '0; row.set_in.load_pos_y = -32'sh0001_0000;
    row.typed_out = '0; row.typed_out.dir_y = -DIR_ONE;
    rows.push_back(row);
    // Two metres along +z.
    row.set_in = '0; row.set_in.load_pos_z = 32'sh0002_0000;
    row.typed_out = '0; row.typed_out.dir_z = DIR_ONE;
    rows.push_back(row);
    // Position extremes on every axis.
    row.kind = ROW_PREDICTED;
    row.set_in = '0;
    row.set_in.vehicle_pos_x = 32'sh7FFF_FFFF; row.set_in.load_pos_x = 32'sh8000_0000;
    row.set_in.vehicle_pos_y = 32'sh7FFF_FFFF; row.set_in.load_pos_y = 32'sh8000_0000;
    row.set_in.vehicle_pos_z = 32'sh7FFF_FFFF; row.set_in.load_pos_z = 32'sh8000_0000;
    rows.push_back(row);
    row.set_in = '0;
    row.set_in.vehicle_pos_x = 32'sh8000_0000; row.set_in.load_pos_x = 32'sh7FFF_FFFF;
    row.set_in.vehicle_pos_y = 32'sh8000_0000; row.set_in.load_pos_y = 32'sh7FFF_FFFF;
    row.set_in.vehicle_pos_z = 32'sh8000_0000; row.set_in.load_pos_z = 32'sh7FFF_FFFF;
    row.set_in.vehicle_vel_x = 32'sh8000_0000; row.set_in.load_vel_x = 32'sh7FFF_FFFF;
    row.set_in.vehicle_vel_y = 32'sh7FFF_FFFF; row.set_in.load_vel_y = 32'sh8000_0000;
    row.set_in.vehicle_vel_z = 32'sh8000_0000; row.set_in.load_vel_z = 32'sh7FFF_FFFF;
    rows.push_back(row);
    // Shortest nonzero cable with extreme velocities: the nonzero rates saturate high.
    row.set_in = '0; row.set_in.load_pos_x = 32'sd1;
    row.set_in.vehicle_vel_y = 32'sh8000_0000; row.set_in.load_vel_y = 32'sh7FFF_FFFF;
    row.set_in.vehicle_vel_z = 32'sh7FFF_FFFF; row.set_in.load_vel_z = 32'sh8000_0000;
    rows.push_back(row);
    row.set_in.load_pos_x = 32'sd0; row.set_in.load_pos_y = -32'sd1;
    rows.push_back(row);
    // Diagonal cable with random velocities, and a length just under one.
    row.set_in = random_set();
    row.set_in.load_pos_x = row.set_in.vehicle_pos_x + 32'sh0001_0000;
    row.set_in.load_pos_y = row.set_in.vehicle_pos_y + 32'sh0001_0000;
    row.set_in.load_pos_z = row.set_in.vehicle_pos_z - 32'sh0001_0000;
    rows.push_back(row);
    row.set_in = random_set();
    row.set_in.load_pos_x = row.set_in.vehicle_pos_x + 32'sh0000_FFFF;
    row.set_in.load_pos_y = row.set_in.vehicle_pos_y;
    row.set_in.load_pos_z = row.set_in.vehicle_pos_z;
    rows.push_back(row);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (rows[i]) send_set(rows[i].kind, rows[i].set_in, rows[i].typed_out);
    drain();

    // A write past the register map must leave the minimum alone.
    write_reg(ADDR_SPARE, 32'h0001_0000);
    send_set(ROW_PREDICTED, rows[9].set_in, '0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(ADDR_MIN_LENGTH, min_settings[ph]);
      quiet = (ph == PHASES - 1);
      repeat (SETS_PER_PHASE) send_set(ROW_PREDICTED, random_set(), '0);
      drain();
    end

    $display("Sent %0d sample sets, checked %0d result words over %0d minimum-length settings.",
             sets_sent, results_seen, PHASES + 1);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
